>>> rtl/sst_pkg.sv
// Shared types and codes for the sorted set table.
package sst_pkg;

  localparam int CAPACITY_DEF = 16;

  typedef logic signed [31:0] value_t;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    value_t     value;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] entry_count;
  } res_t;

  // Per-transfer update orders broadcast to every cell.
  typedef struct packed {
    logic do_insert;
    logic do_delete;
  } cell_ctrl_t;

  // Compare flags a cell hands to its right-hand neighbour and to the encoder.
  typedef struct packed {
    logic ins_ge;   // empty, or entry above the value
    logic at;       // occupied and entry at or above the value
    logic hit_ins;  // first cell where the value goes
    logic hit_fnd;  // first cell that holds the value
  } cell_flags_t;

endpackage

>>> rtl/sst_cell.sv
// One slot of the sorted table: holds an entry, compares it, shifts with its neighbours.
module sst_cell (
  input  logic                clk,
  input  sst_pkg::value_t     value,
  input  logic                occ,
  input  sst_pkg::cell_ctrl_t ctrl,
  input  sst_pkg::value_t     left_entry,
  input  sst_pkg::value_t     right_entry,
  input  sst_pkg::cell_flags_t left_flags,
  output sst_pkg::cell_flags_t flags,
  output sst_pkg::value_t     entry
);
  import sst_pkg::*;

  value_t entry_next;
  logic   eq;

  always_comb begin
    eq            = occ && (entry == value);
    flags.ins_ge  = !occ || (entry > value);
    flags.at      = occ && (entry >= value);
    flags.hit_ins = flags.ins_ge && !left_flags.ins_ge;
    flags.hit_fnd = flags.at && !left_flags.at && eq;
  end

  always_comb begin
    entry_next = entry;
    if (ctrl.do_insert) begin
      if (left_flags.ins_ge) begin
        entry_next = left_entry;
      end else if (flags.ins_ge) begin
        entry_next = value;
      end
    end else if (ctrl.do_delete && flags.at) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

>>> rtl/sorted_set_table.sv
// Top level of the sorted set table: a row of compare-and-shift cells with a result register.
//
//   channel | valid     | stall     | payload         | moves
//   --------+-----------+-----------+-----------------+---------------------------
//   command | cmd_valid | cmd_stall | cmd (cmd_t)     | command and value in
//   result  | res_valid | res_stall | res (res_t)     | status, position, count out
//
// Every cell compares its entry with the value at once and the whole row shifts
// at the clock edge of the transfer, so a command may follow in the very next
// cycle unless the result stalls. The result sits in one output register; a
// new command is taken while that register is empty or being emptied, so a
// stalled result holds the command side. Reset clears the entry count and the
// output valid; entries above the count are never looked at and need no clearing.
module sorted_set_table #(
  parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  sst_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output sst_pkg::res_t res
);
  import sst_pkg::*;

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          room;
  logic          any_match;
  logic [PW-1:0] pos_ins;
  logic [PW-1:0] pos_fnd;
  res_t          res_next;
  cell_ctrl_t    ctrl;

  value_t      entries [CAPACITY];
  cell_flags_t flags   [CAPACITY];

  // Take a command while the result register is free or being drained.
  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign room      = count < CW'(CAPACITY);

  // Build the row; each cell sees its left and right neighbour only.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t      left_e;
    value_t      right_e;
    cell_flags_t left_f;

    if (i == 0) begin : g_first
      assign left_e = cmd.value;
      assign left_f = '0;
    end else begin : g_mid
      assign left_e = entries[i-1];
      assign left_f = flags[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    sst_cell u_cell (
      .clk        (clk),
      .value      (cmd.value),
      .occ        (CW'(i) < count),
      .ctrl       (ctrl),
      .left_entry (left_e),
      .right_entry(right_e),
      .left_flags (left_f),
      .flags      (flags[i]),
      .entry      (entries[i])
    );
  end

  // Encode the one-hot hit lines from the cells into indices.
  always_comb begin
    pos_ins   = '0;
    pos_fnd   = '0;
    any_match = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (flags[i].hit_ins) begin
        pos_ins = pos_ins | PW'(i);
      end
      if (flags[i].hit_fnd) begin
        pos_fnd   = pos_fnd | PW'(i);
        any_match = 1'b1;
      end
    end
  end

  // Decide the update and the result; unused codes act as a find.
  always_comb begin
    ctrl       = '0;
    count_next = count;
    res_next.status   = ST_DONE;
    res_next.position = '0;
    case (cmd.command)
      CMD_INSERT: begin
        if (room) begin
          ctrl.do_insert    = accept;
          count_next        = count + CW'(1);
          res_next.position = 4'(pos_ins);
        end else begin
          res_next.status = ST_FULL;
        end
      end
      CMD_DELETE: begin
        if (any_match) begin
          ctrl.do_delete    = accept;
          count_next        = count - CW'(1);
          res_next.position = 4'(pos_fnd);
        end else begin
          res_next.status = ST_MISS;
        end
      end
      default: begin
        if (any_match) begin
          res_next.position = 4'(pos_fnd);
        end else begin
          res_next.status = ST_MISS;
        end
      end
    endcase
    res_next.entry_count = 5'(count_next);
  end

  // Hold the count and the result register; advance both on a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

endmodule
